@@ hdl/pss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_pkg
// Types, constants and arithmetic helpers for the polynomial stress and
// stiffness evaluator.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int VAL_W         = 48;
  localparam int HALF_W        = VAL_W / 2;
  localparam int PP_W          = 2 * HALF_W;
  localparam int PROD_W        = 2 * VAL_W;
  localparam int SUM_W         = VAL_W + 2;
  localparam int TC_W          = 3;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = VAL_W;
  localparam int MAX_TERMS_DEF = 7;
  localparam int FRAC_BITS_DEF = 24;
  localparam int FQ_DEPTH      = 4;
  localparam int FQ_PTR_W      = 2;
  localparam int FQ_CNT_W      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_TERM_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_BASE  = 4'd1;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    val_t strain_now;
    val_t ref_strain;
    val_t ref_stress;
  } in_item_t;

  typedef struct packed {
    val_t stress_out;
    val_t stiffness_out;
    logic overflow;
  } out_item_t;

  typedef struct packed {
    val_t            eps;
    val_t            ref_stress;
    logic [TC_W-1:0] n;
    logic            ovf;
  } fq_item_t;

  typedef struct packed {
    logic             eps_neg;
    logic [VAL_W-1:0] eps_mag;
    val_t             ref_stress;
    logic [TC_W-1:0]  n;
    logic             ovf;
    val_t             p;
    val_t             d;
  } work_t;

  typedef struct packed {
    logic ovf;
    val_t val;
  } sat_t;

  typedef struct packed {
    logic             ovf;
    logic [VAL_W-1:0] mag;
  } mulr_t;

  function automatic logic signed [SUM_W-1:0] sext_sum(input val_t v);
    return {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
  endfunction

  function automatic sat_t sat_val(input logic signed [SUM_W-1:0] v);
    sat_t r;
    r.ovf = (v[SUM_W-1:VAL_W-1] != '0) && (v[SUM_W-1:VAL_W-1] != '1);
    if (r.ovf) begin
      r.val = v[SUM_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      r.val = v[VAL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] mag_val(input val_t v);
    logic [VAL_W-1:0] u;
    u = v;
    return u[VAL_W-1] ? (~u + VAL_W'(1)) : u;
  endfunction

  function automatic mulr_t mul_round(input logic [PP_W-1:0] ll, input logic [PP_W-1:0] lh,
                                      input logic [PP_W-1:0] hl, input logic [PP_W-1:0] hh,
                                      input logic neg, input int frac);
    logic [PROD_W-1:0] full;
    logic [PROD_W-1:0] q;
    logic [PROD_W-1:0] lim;
    mulr_t             r;
    full = {hh, ll} + (PROD_W'(lh) << HALF_W) + (PROD_W'(hl) << HALF_W)
         + (PROD_W'(1) << (frac - 1));
    q    = full >> frac;
    lim  = neg ? (PROD_W'(1) << (VAL_W - 1)) : ((PROD_W'(1) << (VAL_W - 1)) - PROD_W'(1));
    r.ovf = q > lim;
    r.mag = r.ovf ? lim[VAL_W-1:0] : q[VAL_W-1:0];
    return r;
  endfunction

  function automatic sat_t mul_add(input mulr_t m, input logic neg, input val_t addend);
    logic signed [SUM_W-1:0] pr;
    pr = signed'({{(SUM_W-VAL_W){1'b0}}, m.mag});
    if (neg) begin
      pr = -pr;
    end
    return sat_val(pr + sext_sum(addend));
  endfunction

endpackage

@@ hdl/pss_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_front
// Accepts input items, forms the saturated strain offset and the clamped
// term count, and holds the classified item in a register for the queue.
// ----------------------------------------------------------------------------
module pss_front import pss_pkg::*; #(
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_data,
  input  logic [TC_W-1:0] term_count,
  output logic            fq_valid,
  input  logic            fq_ready,
  output fq_item_t        fq_data
);

  logic     fq_valid_r;
  fq_item_t fq_data_r;
  fq_item_t fq_data_nxt;
  sat_t     eps_sat;

  always_comb begin
    eps_sat = sat_val(sext_sum(in_data.strain_now) - sext_sum(in_data.ref_strain));
    fq_data_nxt.eps        = eps_sat.val;
    fq_data_nxt.ovf        = eps_sat.ovf;
    fq_data_nxt.ref_stress = in_data.ref_stress;
    fq_data_nxt.n = (term_count > TC_W'(MAX_TERMS)) ? TC_W'(MAX_TERMS) : term_count;
  end

  assign in_ready = !fq_valid_r || fq_ready;
  assign fq_valid = fq_valid_r;
  assign fq_data  = fq_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fq_valid_r <= 1'b0;
    end else if (in_ready) begin
      fq_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fq_data_r <= fq_data_nxt;
    end
  end

endmodule

@@ hdl/pss_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_queue
// Short first-in first-out queue of classified items between the front
// and the evaluation pipeline.
// ----------------------------------------------------------------------------
module pss_queue import pss_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  fq_item_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output fq_item_t pop_data
);

  fq_item_t              slot_r [FQ_DEPTH];
  logic [FQ_PTR_W-1:0]   wr_ptr_r;
  logic [FQ_PTR_W-1:0]   rd_ptr_r;
  logic [FQ_CNT_W-1:0]   count_r;
  logic [FQ_CNT_W-1:0]   count_nxt;
  logic                  push;
  logic                  pop;

  assign push_ready = count_r != FQ_CNT_W'(FQ_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + FQ_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - FQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FQ_PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/pss_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_step
// One Horner step with derivative in four register stages: magnitudes,
// partial products, rounding and saturation, then sign and accumulation.
// ----------------------------------------------------------------------------
module pss_step import pss_pkg::*; #(
  parameter int K         = 0,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  vin,
  input  work_t win,
  input  val_t  coef,
  output logic  vout,
  output work_t wout
);

  logic             v0_r, v1_r, v2_r, v3_r;
  work_t            w0_r, w1_r, w2_r, w3_r;
  logic [VAL_W-1:0] pm0_r, dm0_r;
  logic             pn0_r, dn0_r, pn1_r, dn1_r, pn2_r, dn2_r;
  logic [PP_W-1:0]  p_ll_r, p_lh_r, p_hl_r, p_hh_r;
  logic [PP_W-1:0]  d_ll_r, d_lh_r, d_hl_r, d_hh_r;
  mulr_t            pmr2_r, dmr2_r;
  logic [HALF_W-1:0] el, eh;
  work_t            w3_nxt;
  sat_t             p_sum, d_sum;
  logic             active;

  assign el = w0_r.eps_mag[HALF_W-1:0];
  assign eh = w0_r.eps_mag[VAL_W-1:HALF_W];

  always_comb begin
    active = w2_r.n > TC_W'(K);
    p_sum  = mul_add(pmr2_r, pn2_r, coef);
    d_sum  = mul_add(dmr2_r, dn2_r, w2_r.p);
    w3_nxt = w2_r;
    if (active) begin
      w3_nxt.p   = p_sum.val;
      w3_nxt.d   = d_sum.val;
      w3_nxt.ovf = w2_r.ovf | pmr2_r.ovf | dmr2_r.ovf | p_sum.ovf | d_sum.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v0_r <= vin;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w0_r   <= win;
      pm0_r  <= mag_val(win.p);
      dm0_r  <= mag_val(win.d);
      pn0_r  <= win.p[VAL_W-1] ^ win.eps_neg;
      dn0_r  <= win.d[VAL_W-1] ^ win.eps_neg;

      w1_r   <= w0_r;
      pn1_r  <= pn0_r;
      dn1_r  <= dn0_r;
      p_ll_r <= PP_W'(pm0_r[HALF_W-1:0]) * PP_W'(el);
      p_lh_r <= PP_W'(pm0_r[HALF_W-1:0]) * PP_W'(eh);
      p_hl_r <= PP_W'(pm0_r[VAL_W-1:HALF_W]) * PP_W'(el);
      p_hh_r <= PP_W'(pm0_r[VAL_W-1:HALF_W]) * PP_W'(eh);
      d_ll_r <= PP_W'(dm0_r[HALF_W-1:0]) * PP_W'(el);
      d_lh_r <= PP_W'(dm0_r[HALF_W-1:0]) * PP_W'(eh);
      d_hl_r <= PP_W'(dm0_r[VAL_W-1:HALF_W]) * PP_W'(el);
      d_hh_r <= PP_W'(dm0_r[VAL_W-1:HALF_W]) * PP_W'(eh);

      w2_r   <= w1_r;
      pn2_r  <= pn1_r;
      dn2_r  <= dn1_r;
      pmr2_r <= mul_round(p_ll_r, p_lh_r, p_hl_r, p_hh_r, pn1_r, FRAC_BITS);
      dmr2_r <= mul_round(d_ll_r, d_lh_r, d_hl_r, d_hh_r, dn1_r, FRAC_BITS);

      w3_r   <= w3_nxt;
    end
  end

  assign vout = v3_r;
  assign wout = w3_r;

endmodule

@@ hdl/pss_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_back
// Evaluation pipeline: a chain of Horner steps from the highest coefficient
// down to the constant term, the reference stress add and the output register.
// ----------------------------------------------------------------------------
module pss_back import pss_pkg::*; #(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      bq_valid,
  output logic      bq_ready,
  input  fq_item_t  bq_data,
  input  val_t      coef [MAX_TERMS],
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      en;
  logic      sv [MAX_TERMS+1];
  work_t     sw [MAX_TERMS+1];
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t out_data_nxt;
  sat_t      st;

  assign en       = !out_valid_r || out_ready;
  assign bq_ready = en;

  always_comb begin
    sv[0]            = bq_valid;
    sw[0].eps_neg    = bq_data.eps[VAL_W-1];
    sw[0].eps_mag    = mag_val(bq_data.eps);
    sw[0].ref_stress = bq_data.ref_stress;
    sw[0].n          = bq_data.n;
    sw[0].ovf        = bq_data.ovf;
    sw[0].p          = '0;
    sw[0].d          = '0;
  end

  for (genvar j = 0; j < MAX_TERMS; j++) begin : g_step
    pss_step #(
      .K         (MAX_TERMS - 1 - j),
      .FRAC_BITS (FRAC_BITS)
    ) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vin   (sv[j]),
      .win   (sw[j]),
      .coef  (coef[MAX_TERMS-1-j]),
      .vout  (sv[j+1]),
      .wout  (sw[j+1])
    );
  end

  always_comb begin
    st = sat_val(sext_sum(sw[MAX_TERMS].p) + sext_sum(sw[MAX_TERMS].ref_stress));
    out_data_nxt.stress_out    = st.val;
    out_data_nxt.stiffness_out = sw[MAX_TERMS].d;
    out_data_nxt.overflow      = sw[MAX_TERMS].ovf | st.ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sv[MAX_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/polynomial_stress_stiffness_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_stress_stiffness_top
// Evaluates a configured polynomial and its derivative at a strain offset
// from a reference point, giving saturated stress and stiffness.
//
//   Channel  Ports                              Transfer
//   input    in_valid / in_ready / in_data      valid and ready high at clk
//   result   out_valid / out_ready / out_data   valid and ready high at clk
//   config   cfg_we / cfg_index / cfg_wdata     cfg_we high at clk
//
// One item per cycle is sustained while results are taken; each Horner step is four register
// stages with its own partial-product multipliers.
// An item passes the front register, the queue, the Horner steps and the output register.
// Reset clears the control state and all configuration registers to zero.
// A stalled result freezes the evaluation pipeline; the front register and
// a four-entry queue keep taking input transfers until they fill.
// ----------------------------------------------------------------------------
module polynomial_stress_stiffness_top import pss_pkg::*; #(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [TC_W-1:0] term_count_r;
  val_t            coef_r [MAX_TERMS];
  logic            fq_valid, fq_ready;
  fq_item_t        fq_data;
  logic            bq_valid, bq_ready;
  fq_item_t        bq_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= '0;
      for (int i = 0; i < MAX_TERMS; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_TERM_COUNT) begin
        term_count_r <= cfg_wdata[TC_W-1:0];
      end
      for (int i = 0; i < MAX_TERMS; i++) begin
        if (cfg_index == CFG_COEF_BASE + CFG_IDX_W'(i)) begin
          coef_r[i] <= cfg_wdata;
        end
      end
    end
  end

  pss_front #(
    .MAX_TERMS (MAX_TERMS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .term_count (term_count_r),
    .fq_valid   (fq_valid),
    .fq_ready   (fq_ready),
    .fq_data    (fq_data)
  );

  pss_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (bq_valid),
    .pop_ready  (bq_ready),
    .pop_data   (bq_data)
  );

  pss_back #(
    .MAX_TERMS (MAX_TERMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .bq_valid  (bq_valid),
    .bq_ready  (bq_ready),
    .bq_data   (bq_data),
    .coef      (coef_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fq_valid && !fq_ready |=> fq_valid && $stable(fq_data))
    else $error("front item changed while the queue was full");

  a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
    bq_valid && !bq_ready |=> bq_valid && $stable(bq_data))
    else $error("queue head changed while the pipeline was stalled");

  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> fq_valid && !fq_ready)
    else $error("input stalled without a full front and queue");
`endif

endmodule
